// ----- rtl/bpc_pkg.sv -----
// Shared types, constants and the ease table for the breakpoint curve evaluator.
// Used by bpc_cell, bpc_div and breakpoint_curve_table_eval; depends on nothing.
package bpc_pkg;

	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int EASE_DEPTH = 256;
	localparam int EASE_W     = $clog2(EASE_DEPTH + 1);

	localparam logic [15:0] Q_ONE       = 16'hFFFF;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;

	// request codes
	localparam logic [1:0] REQ_EVAL   = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_MOVE   = 2'd3;

	// status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_CLOSE   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_INTERP_MODE = 2'd0;
	localparam logic [1:0] CFG_MIN_GAP     = 2'd1;

	// per-cell edit controls
	typedef struct packed {
		logic load_new;
		logic take_left;
		logic take_right;
	} cell_ctl_t;

	// per-cell compare results against the key
	typedef struct packed {
		logic le;
		logic lt;
		logic close;
	} cell_flags_t;

	// Taylor divisors (2n)(2n+1)
	localparam logic [7:0] TERM_DIV [1:7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156,
		8'd210};

	typedef logic [15:0] ease_rom_t [EASE_DEPTH+1];

	// squared sine quarter wave, built at elaboration
	function automatic ease_rom_t build_ease_rom();
		ease_rom_t   rom;
		logic [63:0] a;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] sq;
		for (int k = 0; k <= EASE_DEPTH; k++) begin
			a    = HALF_PI_Q30 * 64'(k) / EASE_DEPTH;
			sum  = a;
			term = a;
			for (int n = 1; n <= 7; n++) begin
				term = (term * a) >> 30;
				term = (term * a) >> 30;
				term = term / 64'(TERM_DIV[n]);
				if (n % 2 == 1) begin
					sum = (term > sum) ? 64'd0 : sum - term;
				end else begin
					sum = sum + term;
				end
			end
			if (sum > Q30_ONE) begin
				sum = Q30_ONE;
			end
			sq     = (sum * sum) >> 30;
			rom[k] = 16'((sq * 64'(Q_ONE) + (Q30_ONE >> 1)) >> 30);
		end
		return rom;
	endfunction

	localparam ease_rom_t EASE_ROM = build_ease_rom();

	// floor(s / 65535) for s below 2^32 + 2^16
	function automatic logic [15:0] div_q_one(input logic [32:0] s);
		logic [16:0] qe;
		logic [17:0] r;
		logic [16:0] q;
		qe = s[32:16];
		r  = 18'(s[15:0]) + 18'(qe);
		q  = qe + 17'(r >= 18'(Q_ONE)) + 17'(r >= 18'({Q_ONE, 1'b0}));
		return q[15:0];
	endfunction

endpackage

// ----- rtl/bpc_cell.sv -----
// One table cell: holds a single control point and compares it with the key.
// Depends on bpc_pkg.
module bpc_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        init_x,
	input  logic [15:0]        init_y,
	input  bpc_pkg::cell_ctl_t ctl,
	input  logic [15:0]        new_x,
	input  logic [15:0]        new_y,
	input  logic [15:0]        left_x,
	input  logic [15:0]        left_y,
	input  logic [15:0]        right_x,
	input  logic [15:0]        right_y,
	input  logic [15:0]        key,
	input  logic [15:0]        gap,
	output logic [15:0]        x_out,
	output logic [15:0]        y_out,
	output bpc_pkg::cell_flags_t flags
);
	import bpc_pkg::*;

	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [15:0] x_dist;

	// point storage, loaded or shifted from a neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= init_x;
			y_q <= init_y;
		end else if (ctl.load_new) begin
			x_q <= new_x;
			y_q <= new_y;
		end else if (ctl.take_left) begin
			x_q <= left_x;
			y_q <= left_y;
		end else if (ctl.take_right) begin
			x_q <= right_x;
			y_q <= right_y;
		end
	end

	// compares against the key
	assign x_dist      = (key > x_q) ? key - x_q : x_q - key;
	assign flags.le    = x_q <= key;
	assign flags.lt    = x_q < key;
	assign flags.close = x_dist < gap;
	assign x_out       = x_q;
	assign y_out       = y_q;

endmodule

// ----- rtl/bpc_div.sv -----
// Restoring divider, one quotient bit a cycle, for a quotient below 2^16.
// Depends on bpc_pkg.
module bpc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [15:0] den,
	output logic        done,
	output logic [15:0] quo
);
	import bpc_pkg::*;

	logic        run_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] low_q;
	logic [15:0] quo_q;
	logic [15:0] den_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_q, low_q[15]};
	assign fits  = trial >= 17'(den_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[31:16];
			low_q <= num[15:0];
			den_q <= den;
		end else if (run_q) begin
			rem_q <= fits ? 16'(trial - 17'(den_q)) : trial[15:0];
			low_q <= {low_q[14:0], 1'b0};
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- rtl/breakpoint_curve_table_eval.sv -----
// Top level: cell row, request sequencer, blend datapath and config registers.
// Depends on bpc_pkg, bpc_cell and bpc_div.
//
// channel   signals                                   direction  handshake
// request   start, busy, req_type, x_in, y_in, index  in         start & !busy
// result    done, y_out, status, point_count          out        done strobe, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid & cfg_ready
//
// An edit finishes in S_EXEC, which raises the result strobe. An evaluation ends in
// S_EXEC when no segment holds x, and otherwise passes S_DIV for the serial divider
// (skipped for a zero-width segment), then S_EASE, S_EMUL and S_ESUM in cosine mode
// (S_EASE alone when t reaches the end of the ease table), then S_YMUL and S_YSUM.
// Reset puts the anchors in cells 0 and 1 and the count at 2. The result strobe
// cannot be stalled; cfg_ready is always high.
module breakpoint_curve_table_eval (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] x_in,
	input  logic [15:0] y_in,
	input  logic [3:0]  index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [15:0] y_out,
	output logic [1:0]  status,
	output logic [4:0]  point_count
);
	import bpc_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_EXEC = 8'b0000_0010,
		S_DIV  = 8'b0000_0100,
		S_EASE = 8'b0000_1000,
		S_EMUL = 8'b0001_0000,
		S_ESUM = 8'b0010_0000,
		S_YMUL = 8'b0100_0000,
		S_YSUM = 8'b1000_0000
	} state_t;

	localparam int P_W = 16 + EASE_W;

	state_t         state_q;
	logic [1:0]     req_q;
	logic [15:0]    rx_q;
	logic [15:0]    ry_q;
	logic [IDX_W-1:0] ridx_q;
	logic           mode_q;
	logic [15:0]    gap_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]    y0_q, y1_q, tw_q;
	logic [15:0]    ba_q, bb_q, bw_q;
	logic [31:0]    pa_q, pb_q;
	logic           done_q;
	logic [15:0]    yout_q;
	logic [1:0]     stat_q;
	logic [CNT_W-1:0] pcnt_q;

	logic [15:0]  xs [MAX_POINTS];
	logic [15:0]  ys [MAX_POINTS];
	cell_ctl_t    ctl [MAX_POINTS];
	cell_flags_t  fl [MAX_POINTS];
	logic [MAX_POINTS-1:0] valid;
	logic [MAX_POINTS-2:0] seg;

	logic [15:0] new_x;
	logic        found;
	logic [IDX_W-1:0] sel;
	logic [IDX_W-1:0] pos;
	logic        pos_hit;
	logic        close_any;
	logic [15:0] x0, x1, dx, den;
	logic [31:0] div_num;
	logic        div_start, div_done;
	logic [15:0] div_quo;

	logic [1:0]       ed_stat;
	logic [CNT_W-1:0] ed_count;
	logic [16:0]      lo_sum;
	logic [15:0]      lo, hi, nb_lo, nb_hi, mx;

	logic [P_W-1:0]    pe;
	logic [EASE_W-1:0] qe, ei;
	logic [16:0]       re;
	logic [15:0]       ef;
	logic [15:0]       sum_res;

	// cell row
	for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
		logic [15:0] lx, ly, rx, ry;
		if (j == 0) begin : g_l0
			assign lx = '0;
			assign ly = '0;
		end else begin : g_l
			assign lx = xs[j-1];
			assign ly = ys[j-1];
		end
		if (j == MAX_POINTS - 1) begin : g_rn
			assign rx = '0;
			assign ry = '0;
		end else begin : g_r
			assign rx = xs[j+1];
			assign ry = ys[j+1];
		end
		bpc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.init_x  ((j == 1) ? Q_ONE : 16'd0),
			.init_y  ((j == 1) ? Q_ONE : 16'd0),
			.ctl     (ctl[j]),
			.new_x   (new_x),
			.new_y   (ry_q),
			.left_x  (lx),
			.left_y  (ly),
			.right_x (rx),
			.right_y (ry),
			.key     (rx_q),
			.gap     (gap_q),
			.x_out   (xs[j]),
			.y_out   (ys[j]),
			.flags   (fl[j])
		);
		assign valid[j] = CNT_W'(j) < count_q;
	end

	for (genvar i = 0; i < MAX_POINTS - 1; i++) begin : g_seg
		assign seg[i] = valid[i+1] && fl[i].le && !fl[i+1].lt;
	end

	// first holding segment, insert position, closeness
	always_comb begin
		found     = 1'b0;
		sel       = '0;
		pos_hit   = 1'b0;
		pos       = '0;
		close_any = 1'b0;
		for (int i = MAX_POINTS - 2; i >= 0; i--) begin
			if (seg[i]) begin
				found = 1'b1;
				sel   = IDX_W'(i);
			end
		end
		for (int j = MAX_POINTS - 1; j >= 0; j--) begin
			if (valid[j] && !fl[j].le) begin
				pos_hit = 1'b1;
				pos     = IDX_W'(j);
			end
			if (valid[j] && fl[j].close) begin
				close_any = 1'b1;
			end
		end
		if (!pos_hit) begin
			pos = IDX_W'(count_q);
		end
	end

	// segment operands and divider feed
	assign x0        = xs[sel];
	assign x1        = xs[sel + IDX_W'(1)];
	assign dx        = rx_q - x0;
	assign den       = x1 - x0;
	assign div_num   = {dx, 16'd0} - 32'(dx) + 32'(den >> 1);
	assign div_start = (state_q == S_EXEC) && (req_q == REQ_EVAL) && found && (den != 16'd0);

	bpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// move clamp
	assign nb_lo  = xs[ridx_q - IDX_W'(1)];
	assign nb_hi  = xs[ridx_q + IDX_W'(1)];
	assign lo_sum = 17'(nb_lo) + 17'(gap_q);
	assign lo     = lo_sum[16] ? Q_ONE : lo_sum[15:0];
	assign hi     = (nb_hi >= gap_q) ? nb_hi - gap_q : 16'd0;

	always_comb begin
		mx = (rx_q > hi) ? hi : rx_q;
		if (mx < lo) begin
			mx = lo;
		end
		if (ridx_q == '0) begin
			mx = 16'd0;
		end else if (CNT_W'(ridx_q) + CNT_W'(1) == count_q) begin
			mx = Q_ONE;
		end
	end

	// edit decode
	always_comb begin
		ed_stat  = ST_DONE;
		ed_count = count_q;
		new_x    = rx_q;
		for (int j = 0; j < MAX_POINTS; j++) begin
			ctl[j] = '0;
		end
		if (state_q == S_EXEC) begin
			case (req_q)
				REQ_ADD: begin
					if (close_any) begin
						ed_stat = ST_CLOSE;
					end else if (count_q >= CNT_W'(MAX_POINTS)) begin
						ed_stat = ST_FULL;
					end else begin
						ed_count = count_q + CNT_W'(1);
						for (int j = 0; j < MAX_POINTS; j++) begin
							ctl[j].load_new  = IDX_W'(j) == pos;
							ctl[j].take_left = (IDX_W'(j) > pos) && (CNT_W'(j) <= count_q);
						end
					end
				end
				REQ_REMOVE: begin
					if (ridx_q == '0 || CNT_W'(ridx_q) + CNT_W'(1) >= count_q) begin
						ed_stat = ST_IGNORED;
					end else begin
						ed_count = count_q - CNT_W'(1);
						for (int j = 0; j < MAX_POINTS; j++) begin
							ctl[j].take_right = (IDX_W'(j) >= ridx_q) &&
								(CNT_W'(j) + CNT_W'(1) < count_q);
						end
					end
				end
				REQ_MOVE: begin
					if (CNT_W'(ridx_q) >= count_q) begin
						ed_stat = ST_IGNORED;
					end else begin
						new_x = mx;
						for (int j = 0; j < MAX_POINTS; j++) begin
							ctl[j].load_new = IDX_W'(j) == ridx_q;
						end
					end
				end
				default: begin
					ed_stat = ST_DONE;
				end
			endcase
		end
	end

	// ease table index split: t*D = i*65535 + f
	always_comb begin
		pe = P_W'(tw_q) * P_W'(EASE_DEPTH);
		qe = pe[P_W-1:16];
		re = 17'(pe[15:0]) + 17'(qe);
		if (re >= 17'(Q_ONE)) begin
			ei = qe + EASE_W'(1);
			ef = 16'(re - 17'(Q_ONE));
		end else begin
			ei = qe;
			ef = re[15:0];
		end
	end

	assign sum_res = div_q_one(33'(pa_q) + 33'(pb_q) + 33'd32767);

	// sequencer, point count and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= CNT_W'(2);
			mode_q  <= 1'b0;
			gap_q   <= 16'd655;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_INTERP_MODE: mode_q <= cfg_data[0];
					CFG_MIN_GAP:     gap_q  <= cfg_data;
					default:         ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (req_q != REQ_EVAL) begin
						count_q <= ed_count;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (!found) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (den != 16'd0) begin
						state_q <= S_DIV;
					end else if (mode_q) begin
						state_q <= S_EASE;
					end else begin
						state_q <= S_YMUL;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= mode_q ? S_EASE : S_YMUL;
					end
				end
				S_EASE: begin
					state_q <= (ei >= EASE_W'(EASE_DEPTH)) ? S_YMUL : S_EMUL;
				end
				S_EMUL: state_q <= S_ESUM;
				S_ESUM: state_q <= S_YMUL;
				S_YMUL: state_q <= S_YSUM;
				S_YSUM: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q  <= req_type;
					rx_q   <= x_in;
					ry_q   <= y_in;
					ridx_q <= index;
				end
			end
			S_EXEC: begin
				y0_q <= ys[sel];
				y1_q <= ys[sel + IDX_W'(1)];
				tw_q <= 16'd0;
				ba_q <= ys[sel];
				bb_q <= ys[sel + IDX_W'(1)];
				bw_q <= 16'd0;
				if (req_q != REQ_EVAL) begin
					yout_q <= 16'd0;
					stat_q <= ed_stat;
					pcnt_q <= ed_count;
				end else if (!found) begin
					yout_q <= ys[IDX_W'(count_q - CNT_W'(1))];
					stat_q <= ST_DONE;
					pcnt_q <= count_q;
				end
			end
			S_DIV: begin
				tw_q <= div_quo;
				bw_q <= div_quo;
			end
			S_EASE: begin
				if (ei >= EASE_W'(EASE_DEPTH)) begin
					bw_q <= EASE_ROM[EASE_DEPTH];
					ba_q <= y0_q;
					bb_q <= y1_q;
				end else begin
					ba_q <= EASE_ROM[ei];
					bb_q <= EASE_ROM[ei + EASE_W'(1)];
					bw_q <= ef;
				end
			end
			S_EMUL, S_YMUL: begin
				pa_q <= 32'(Q_ONE - bw_q) * 32'(ba_q);
				pb_q <= 32'(bw_q) * 32'(bb_q);
			end
			S_ESUM: begin
				bw_q <= sum_res;
				ba_q <= y0_q;
				bb_q <= y1_q;
			end
			S_YSUM: begin
				yout_q <= sum_res;
				stat_q <= ST_DONE;
				pcnt_q <= count_q;
			end
			default: ;
		endcase
	end

	assign busy        = state_q != S_IDLE;
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign y_out       = yout_q;
	assign status      = stat_q;
	assign point_count = pcnt_q;

endmodule
